FILE: design/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro builds one labeled concurrent assertion on clk with reset arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: the antecedent holding implies the consequent.
`define SKF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: the antecedent holding implies the consequent in the next cycle.
`define SKF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// Types, constants and register codes of the scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

	// Fixed-point one for the gain, Q1.24.
	localparam logic [24:0] GainOne = 25'h100_0000;

	// Reset values of registers and state.
	localparam logic [31:0] ProcessNoiseRst     = 32'd167772;
	localparam logic [31:0] MeasurementNoiseRst = 32'd1509949;
	localparam logic [31:0] CovarianceRst       = 32'd33554;

	// Number of quotient bits produced by the serial divider.
	localparam int unsigned DivSteps = 25;
	localparam int unsigned DivCntW  = $clog2(DivSteps);

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_PROCESS_NOISE     = 1'b0,
		REG_MEASUREMENT_NOISE = 1'b1
	} skf_reg_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRED,
		ST_DIV,
		ST_MULA,
		ST_MULB,
		ST_WB
	} skf_state_t;

	// Request to the divider: numerator is p, the quotient is p * 2^24 / den.
	typedef struct packed {
		logic        start;
		logic [31:0] num;
		logic [32:0] den;
	} skf_div_req_t;

	// Divider response: done pulses for one cycle with the quotient valid.
	typedef struct packed {
		logic        done;
		logic [24:0] quot;
	} skf_div_rsp_t;

endpackage

FILE: design/scalar_kalman_filter.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter: one-dimensional Kalman smoother for one sensor channel.
// A sample runs ST_PRED, ST_DIV (25-step serial divide), ST_MULA, ST_MULB and ST_WB.
// The next sample is taken in ST_IDLE, once the result is in the output register.
// Reset (arst_n low) restores the noise registers, zero estimate, covariance 0.002.
// ----------------------------------------------------------------------------
module scalar_kalman_filter
	import skf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// Input stream: [15:0] sample.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,
	// Output stream: [31:0] estimate, [56:32] gain, [63:57] zero.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata
);

	skf_state_t state_q, state_d;

	logic [31:0] q_q;
	logic [31:0] r_q;
	logic [31:0] est_q;
	logic [31:0] cov_q;
	logic [15:0] sample_q;
	logic [31:0] p_q;
	logic [33:0] diff_q;
	logic [24:0] k_q;

	logic        out_valid_q;
	logic [31:0] out_est_q;
	logic [24:0] out_gain_q;

	logic        out_free;
	logic        ld_sample;
	logic        ld_pred;
	logic        ld_k;
	logic        ld_est;
	logic        ld_out;
	logic        mul_cov;
	logic        div_start;

	logic [32:0] pred_sum;
	logic [31:0] p_sat;
	logic [33:0] diff_d;

	skf_div_req_t div_req;
	skf_div_rsp_t div_rsp;

	logic signed [34:0] mul_a;
	logic signed [25:0] mul_b;
	logic signed [60:0] prod;

	logic signed [33:0] delta;
	logic signed [34:0] est_sum;
	logic [31:0]        est_sat;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= ProcessNoiseRst;
			r_q <= MeasurementNoiseRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROCESS_NOISE:     q_q <= cfg_data;
				REG_MEASUREMENT_NOISE: r_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Prediction with saturation, and the innovation at 34 bits.
	assign pred_sum = {1'b0, cov_q} + {1'b0, q_q};
	assign p_sat    = pred_sum[32] ? '1 : pred_sum[31:0];
	assign diff_d   = {{2{sample_q[15]}}, sample_q, 16'h0000} - {{2{est_q[31]}}, est_q};

	// Divider request: start, numerator p and the 33-bit denominator p + r.
	assign div_req = {div_start, p_sat, {1'b0, p_sat} + {1'b0, r_q}};

	skf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Multiplier operands: innovation times gain, then (1 - k) times p.
	assign mul_a = mul_cov ? $signed({3'b000, p_q}) : $signed({diff_q[33], diff_q});
	assign mul_b = mul_cov ? $signed({1'b0, GainOne - k_q}) : $signed({1'b0, k_q});

	skf_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Floor shift by 24 and saturating update of the estimate.
	assign delta   = prod[57:24];
	assign est_sum = {{3{est_q[31]}}, est_q} + {delta[33], delta};
	always_comb begin
		if (est_sum > 35'sd2147483647) begin
			est_sat = 32'h7FFF_FFFF;
		end else if (est_sum < -35'sd2147483648) begin
			est_sat = 32'h8000_0000;
		end else begin
			est_sat = est_sum[31:0];
		end
	end

	assign out_free = !out_valid_q || m_tready;

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_PRED;
			ST_PRED: state_d = ST_DIV;
			ST_DIV:  if (div_rsp.done) state_d = ST_MULA;
			ST_MULA: state_d = ST_MULB;
			ST_MULB: state_d = ST_WB;
			ST_WB:   if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		s_tready  = 1'b0;
		ld_sample = 1'b0;
		ld_pred   = 1'b0;
		div_start = 1'b0;
		ld_k      = 1'b0;
		ld_est    = 1'b0;
		ld_out    = 1'b0;
		mul_cov   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				ld_sample = s_tvalid;
			end
			ST_PRED: begin
				ld_pred   = 1'b1;
				div_start = 1'b1;
			end
			ST_DIV:  ld_k = div_rsp.done;
			ST_MULA: mul_cov = 1'b0;
			ST_MULB: begin
				mul_cov = 1'b1;
				ld_est  = 1'b1;
			end
			ST_WB: begin
				mul_cov = 1'b1;
				ld_out  = out_free;
			end
			default: ;
		endcase
	end

	// Control state: sequencer, filter state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			est_q       <= '0;
			cov_q       <= CovarianceRst;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld_est) begin
				est_q <= est_sat;
			end
			if (ld_out) begin
				cov_q       <= prod[55:24];
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and the output beat.
	always_ff @(posedge clk) begin
		if (ld_sample) begin
			sample_q <= s_tdata;
		end
		if (ld_pred) begin
			p_q    <= p_sat;
			diff_q <= diff_d;
		end
		if (ld_k) begin
			k_q <= div_rsp.quot;
		end
		if (ld_out) begin
			out_est_q  <= est_q;
			out_gain_q <= k_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0000000, out_gain_q, out_est_q};

endmodule

FILE: design/skf_div.sv
// ----------------------------------------------------------------------------
// skf_div
// Restoring serial divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module skf_div
	import skf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  skf_div_req_t req,
	output skf_div_rsp_t rsp
);

	logic [33:0]        rem_q;
	logic [32:0]        den_q;
	logic [24:0]        quo_q;
	logic [DivCntW-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;
	logic               zero_q;

	logic        ge;
	logic [33:0] rem_sub;

	// One compare and subtract against the divisor.
	assign ge      = rem_q >= {1'b0, den_q};
	assign rem_sub = ge ? (rem_q - {1'b0, den_q}) : rem_q;

	// Control state of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DivCntW'(DivSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Datapath: partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= {2'b00, req.num};
			den_q  <= req.den;
			zero_q <= (req.den == '0);
			quo_q  <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[23:0], ge};
			rem_q <= {rem_sub[32:0], 1'b0};
		end
	end

	// A zero divisor gives a zero gain.
	assign rsp.done = done_q;
	assign rsp.quot = zero_q ? '0 : quo_q;

endmodule

FILE: design/skf_mul.sv
// ----------------------------------------------------------------------------
// skf_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module skf_mul
	import skf_pkg::*;
(
	input  logic               clk,
	input  logic signed [34:0] a,
	input  logic signed [25:0] b,
	output logic signed [60:0] prod
);

	logic signed [60:0] prod_q;

	// Product register; it follows the operands every cycle.
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

FILE: design/skf_checker.sv
// ----------------------------------------------------------------------------
// skf_checker
// Port-level checks of the scalar Kalman filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module skf_checker
	import skf_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);

	// A stalled output beat keeps its data.
	`SKF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output beat changed while stalled")

	// One sample at a time: after an accepted beat the input stays closed.
	`SKF_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input reopened right after a beat")

	// The gain never exceeds one in Q1.24.
	`SKF_ASSERT_NOW(a_gain_range, m_tvalid, m_tdata[56:32] <= GainOne, "gain above one")

	// Padding bits of the output beat are zero.
	`SKF_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[63:57] == 7'b0000000, "padding bits set")

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (.*);
